/* hw/rtl/spcc_pkg.sv */
// ============================================================================
// spcc_pkg: shared types and constants of the segment pair crossing classifier
// Holds the class codes, the place codes of a rational against [0,1], the
// routing kinds decided at the front of the pipeline and the flag bundle
// that travels with each pair.
// ============================================================================
`default_nettype none

package spcc_pkg;

    // Width of one coordinate field on the input stream.
    localparam int unsigned FIELD_BITS = 16;
    localparam int unsigned NUM_FIELDS = 8;
    localparam int unsigned IN_BITS    = FIELD_BITS * NUM_FIELDS;
    localparam int unsigned CLASS_BITS = 3;
    localparam int unsigned OUT_BITS   = 8;

    // Crossing classes.
    localparam logic [CLASS_BITS-1:0] CLS_NONE    = 3'd0;
    localparam logic [CLASS_BITS-1:0] CLS_SHARED  = 3'd1;
    localparam logic [CLASS_BITS-1:0] CLS_PROPER  = 3'd2;
    localparam logic [CLASS_BITS-1:0] CLS_A_START = 3'd3;
    localparam logic [CLASS_BITS-1:0] CLS_A_END   = 3'd4;
    localparam logic [CLASS_BITS-1:0] CLS_B_START = 3'd5;
    localparam logic [CLASS_BITS-1:0] CLS_B_END   = 3'd6;
    localparam logic [CLASS_BITS-1:0] CLS_OVERLAP = 3'd7;

    // Where a ratio n/d lies relative to the unit interval.
    typedef enum logic [1:0] {
        PLACE_ZERO = 2'd0,
        PLACE_ONE  = 2'd1,
        PLACE_MID  = 2'd2,
        PLACE_OUT  = 2'd3
    } place_t;

    // How the final class is picked at the back of the pipeline.
    typedef enum logic [1:0] {
        KIND_FIXED   = 2'd0,  // class already known from coordinate compares
        KIND_PT_A    = 2'd1,  // segment A is a point, B is slanted
        KIND_PT_B    = 2'd2,  // segment B is a point, A is slanted
        KIND_GENERAL = 2'd3   // both segments have length
    } kind_t;

    typedef struct packed {
        kind_t                 kind;
        logic [CLASS_BITS-1:0] fixed_class;
        logic [CLASS_BITS-1:0] col_class;
        logic [CLASS_BITS-1:0] pt_class;
    } flags_t;

endpackage

`default_nettype wire

/* hw/rtl/spcc_prep.sv */
// ============================================================================
// spcc_prep: coordinate capture and difference stage
// Stage 1 registers the coordinates. Stage 2 forms the edge
// and offset vectors and settles every case that needs only coordinate
// compares: point segments against axis-aligned segments and the collinear
// span class.
// ============================================================================
`default_nettype none

module spcc_prep
    import spcc_pkg::*;
#(
    parameter int unsigned COORD_BITS = 16
)(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [IN_BITS-1:0]             in_data,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic signed [COORD_BITS:0]          rx,
    output logic signed [COORD_BITS:0]          ry,
    output logic signed [COORD_BITS:0]          sx,
    output logic signed [COORD_BITS:0]          sy,
    output logic signed [COORD_BITS:0]          qx,
    output logic signed [COORD_BITS:0]          qy,
    output flags_t                              flags
);

    localparam int unsigned CW = COORD_BITS;
    localparam int unsigned DW = COORD_BITS + 1;

    logic signed [CW-1:0] coord_next [NUM_FIELDS];
    logic signed [CW-1:0] coord_reg  [NUM_FIELDS];
    logic                 v1_reg;
    logic                 v2_reg;
    logic                 rdy1;
    logic                 rdy2;

    logic signed [CW-1:0] x11, y11, x12, y12, x21, y21, x22, y22;
    logic signed [DW-1:0] rx_next, ry_next, sx_next, sy_next, qx_next, qy_next;
    logic signed [DW-1:0] rx_reg, ry_reg, sx_reg, sy_reg, qx_reg, qy_reg;
    flags_t               flags_next;
    flags_t               flags_reg;
    logic                 a_pt;
    logic                 b_pt;
    logic                 shared_end;
    logic [CLASS_BITS-1:0] col_cls;

    // Each field is read from its low bits; wider coordinates zero-extend.
    genvar gi;
    generate
        for (gi = 0; gi < NUM_FIELDS; gi++)
        begin : g_field
            if (COORD_BITS <= FIELD_BITS)
            begin : g_narrow
                assign coord_next[gi] = in_data[gi*FIELD_BITS +: CW];
            end
            else
            begin : g_wide
                assign coord_next[gi] = {{(CW-FIELD_BITS){1'b0}},
                                         in_data[gi*FIELD_BITS +: FIELD_BITS]};
            end
        end
    endgenerate

    function automatic logic signed [CW-1:0] mn(input logic signed [CW-1:0] a,
                                                 input logic signed [CW-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic signed [CW-1:0] mx(input logic signed [CW-1:0] a,
                                                 input logic signed [CW-1:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic [CLASS_BITS-1:0] span_class(
        input logic signed [CW-1:0] a1, input logic signed [CW-1:0] a2,
        input logic signed [CW-1:0] b1, input logic signed [CW-1:0] b2);
        logic signed [CW-1:0] amax;
        logic signed [CW-1:0] amin;
        logic signed [CW-1:0] bmax;
        logic signed [CW-1:0] bmin;
        logic [CLASS_BITS-1:0] r;
        amax = mx(a1, a2);
        amin = mn(a1, a2);
        bmax = mx(b1, b2);
        bmin = mn(b1, b2);
        priority if (amax >= bmin && amin <= bmax)
        begin
            r = (amax == bmin || amin == bmax) ? CLS_SHARED : CLS_OVERLAP;
        end
        else
        begin
            r = CLS_NONE;
        end
        return r;
    endfunction

    // Point on an axis-aligned segment: on_line tells that the point sits on
    // the segment's line, pa is the point's coordinate along it.
    function automatic logic [CLASS_BITS-1:0] axis_point(
        input logic on_line, input logic signed [CW-1:0] pa,
        input logic signed [CW-1:0] e1, input logic signed [CW-1:0] e2);
        logic [CLASS_BITS-1:0] r;
        priority if (on_line && (e1 == pa || e2 == pa))
            r = CLS_SHARED;
        else if (on_line && mn(e1, e2) <= pa && mx(e1, e2) >= pa)
            r = CLS_PROPER;
        else
            r = CLS_NONE;
        return r;
    endfunction

    assign rdy2     = !v2_reg || out_ready;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
            coord_reg <= coord_next;
    end

    assign x11 = coord_reg[0];
    assign y11 = coord_reg[1];
    assign x12 = coord_reg[2];
    assign y12 = coord_reg[3];
    assign x21 = coord_reg[4];
    assign y21 = coord_reg[5];
    assign x22 = coord_reg[6];
    assign y22 = coord_reg[7];

    assign rx_next = DW'(x12) - DW'(x11);
    assign ry_next = DW'(y12) - DW'(y11);
    assign sx_next = DW'(x22) - DW'(x21);
    assign sy_next = DW'(y22) - DW'(y21);
    assign qx_next = DW'(x21) - DW'(x11);
    assign qy_next = DW'(y21) - DW'(y11);

    assign a_pt = (x11 == x12) && (y11 == y12);
    assign b_pt = (x21 == x22) && (y21 == y22);
    assign shared_end = (x11 == x21 && y11 == y21) || (x11 == x22 && y11 == y22) ||
                        (x12 == x21 && y12 == y21) || (x12 == x22 && y12 == y22);

    // Collinear class, used only when both cross products vanish.
    always_comb
    begin
        priority if (y11 == y21)
            col_cls = span_class(x11, x12, x21, x22);
        else if (x11 == x12)
            col_cls = span_class(y11, y12, y21, y22);
        else if (shared_end && (mx(x11, x12) <= mn(x21, x22) ||
                                mn(x11, x12) >= mx(x21, x22)))
            col_cls = CLS_SHARED;
        else if (mn(x11, x12) < mx(x21, x22) && mx(x11, x12) > mn(x21, x22))
            col_cls = CLS_OVERLAP;
        else
            col_cls = CLS_NONE;
    end

    always_comb
    begin
        flags_next.kind        = KIND_GENERAL;
        flags_next.fixed_class = CLS_NONE;
        flags_next.col_class   = col_cls;
        flags_next.pt_class    = CLS_NONE;
        priority if (a_pt && b_pt)
        begin
            flags_next.kind = KIND_FIXED;
        end
        else if (a_pt)
        begin
            priority if (x21 == x22)
            begin
                flags_next.kind        = KIND_FIXED;
                flags_next.fixed_class = axis_point(x11 == x21, y11, y21, y22);
            end
            else if (y21 == y22)
            begin
                flags_next.kind        = KIND_FIXED;
                flags_next.fixed_class = axis_point(y11 == y21, x11, x21, x22);
            end
            else
            begin
                flags_next.kind = KIND_PT_A;
            end
        end
        else if (b_pt)
        begin
            priority if (x11 == x12)
            begin
                flags_next.kind        = KIND_FIXED;
                flags_next.fixed_class = axis_point(x21 == x11, y21, y11, y12);
            end
            else if (y11 == y12)
            begin
                flags_next.kind        = KIND_FIXED;
                flags_next.fixed_class = axis_point(y21 == y11, x21, x11, x12);
            end
            else
            begin
                flags_next.kind = KIND_PT_B;
            end
        end
        else
        begin
            flags_next.kind = KIND_GENERAL;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy2 && v1_reg)
        begin
            rx_reg    <= rx_next;
            ry_reg    <= ry_next;
            sx_reg    <= sx_next;
            sy_reg    <= sy_next;
            qx_reg    <= qx_next;
            qy_reg    <= qy_next;
            flags_reg <= flags_next;
        end
    end

    assign out_valid = v2_reg;
    assign rx        = rx_reg;
    assign ry        = ry_reg;
    assign sx        = sx_reg;
    assign sy        = sy_reg;
    assign qx        = qx_reg;
    assign qy        = qy_reg;
    assign flags     = flags_reg;

endmodule

`default_nettype wire

/* hw/rtl/spcc_mult.sv */
// ============================================================================
// spcc_mult: cross product multiplier stage
// Forms the six partial products of the three cross products in one
// registered stage, and places the point-segment ratio for the point cases.
// ============================================================================
`default_nettype none

module spcc_mult
    import spcc_pkg::*;
#(
    parameter int unsigned COORD_BITS = 16
)(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic signed [COORD_BITS:0]      rx,
    input  wire logic signed [COORD_BITS:0]      ry,
    input  wire logic signed [COORD_BITS:0]      sx,
    input  wire logic signed [COORD_BITS:0]      sy,
    input  wire logic signed [COORD_BITS:0]      qx,
    input  wire logic signed [COORD_BITS:0]      qy,
    input  wire flags_t                          in_flags,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic signed [2*COORD_BITS+1:0]       p_rx_sy,
    output logic signed [2*COORD_BITS+1:0]       p_ry_sx,
    output logic signed [2*COORD_BITS+1:0]       p_qx_ry,
    output logic signed [2*COORD_BITS+1:0]       p_qy_rx,
    output logic signed [2*COORD_BITS+1:0]       p_qx_sy,
    output logic signed [2*COORD_BITS+1:0]       p_qy_sx,
    output flags_t                               out_flags
);

    localparam int unsigned DW = COORD_BITS + 1;
    localparam int unsigned PW = 2 * DW;

    logic                 v_reg;
    logic                 rdy;
    logic signed [DW-1:0] pt_n;
    logic signed [DW-1:0] pt_d;
    place_t               pt_place;
    flags_t               flags_next;
    flags_t               flags_reg;
    logic signed [PW-1:0] p_rx_sy_reg, p_ry_sx_reg, p_qx_ry_reg;
    logic signed [PW-1:0] p_qy_rx_reg, p_qx_sy_reg, p_qy_sx_reg;

    function automatic place_t place_of(input logic signed [DW-1:0] n,
                                        input logic signed [DW-1:0] d);
        logic signed [DW:0] nn;
        logic signed [DW:0] dd;
        place_t             r;
        nn = d[DW-1] ? -((DW+1)'(n)) : (DW+1)'(n);
        dd = d[DW-1] ? -((DW+1)'(d)) : (DW+1)'(d);
        priority if (nn == '0)
            r = PLACE_ZERO;
        else if (nn == dd)
            r = PLACE_ONE;
        else if (nn > 0 && nn < dd)
            r = PLACE_MID;
        else
            r = PLACE_OUT;
        return r;
    endfunction

    // Point A against B uses -qx/sx; point B against A uses qx/rx.
    assign pt_n     = (in_flags.kind == KIND_PT_A) ? -qx : qx;
    assign pt_d     = (in_flags.kind == KIND_PT_A) ? sx : rx;
    assign pt_place = place_of(pt_n, pt_d);

    always_comb
    begin
        flags_next = in_flags;
        unique case (pt_place)
            PLACE_ZERO, PLACE_ONE: flags_next.pt_class = CLS_SHARED;
            PLACE_MID:             flags_next.pt_class = CLS_PROPER;
            default:               flags_next.pt_class = CLS_NONE;
        endcase
    end

    assign rdy      = !v_reg || out_ready;
    assign in_ready = rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (rdy)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (rdy && in_valid)
        begin
            p_rx_sy_reg <= PW'(rx) * PW'(sy);
            p_ry_sx_reg <= PW'(ry) * PW'(sx);
            p_qx_ry_reg <= PW'(qx) * PW'(ry);
            p_qy_rx_reg <= PW'(qy) * PW'(rx);
            p_qx_sy_reg <= PW'(qx) * PW'(sy);
            p_qy_sx_reg <= PW'(qy) * PW'(sx);
            flags_reg   <= flags_next;
        end
    end

    assign out_valid = v_reg;
    assign p_rx_sy   = p_rx_sy_reg;
    assign p_ry_sx   = p_ry_sx_reg;
    assign p_qx_ry   = p_qx_ry_reg;
    assign p_qy_rx   = p_qy_rx_reg;
    assign p_qx_sy   = p_qx_sy_reg;
    assign p_qy_sx   = p_qy_sx_reg;
    assign out_flags = flags_reg;

endmodule

`default_nettype wire

/* hw/rtl/spcc_decide.sv */
// ============================================================================
// spcc_decide: cross product, placement and class selection stages
// Stage 4 subtracts the partial products into the denominator and the two
// numerators. Stage 5 places both intersection parameters against [0,1].
// Stage 6 picks the class and is the output register.
// ============================================================================
`default_nettype none

module spcc_decide
    import spcc_pkg::*;
#(
    parameter int unsigned COORD_BITS = 16
)(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic signed [2*COORD_BITS+1:0]  p_rx_sy,
    input  wire logic signed [2*COORD_BITS+1:0]  p_ry_sx,
    input  wire logic signed [2*COORD_BITS+1:0]  p_qx_ry,
    input  wire logic signed [2*COORD_BITS+1:0]  p_qy_rx,
    input  wire logic signed [2*COORD_BITS+1:0]  p_qx_sy,
    input  wire logic signed [2*COORD_BITS+1:0]  p_qy_sx,
    input  wire flags_t                          in_flags,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [CLASS_BITS-1:0]                crossing_class
);

    localparam int unsigned PW = 2 * (COORD_BITS + 1);
    localparam int unsigned SW = PW + 1;

    logic                  v4_reg, v5_reg, v6_reg;
    logic                  rdy4, rdy5, rdy6;
    logic signed [SW-1:0]  d_next, sn_next, rn_next;
    logic signed [SW-1:0]  d_reg, sn_reg, rn_reg;
    flags_t                flags4_reg;
    flags_t                flags5_reg;
    place_t                pr_next, ps_next;
    place_t                pr_reg, ps_reg;
    logic                  d_zero_reg, sn_zero_reg, rn_zero_reg;
    logic [CLASS_BITS-1:0] cross_cls;
    logic [CLASS_BITS-1:0] class_next;
    logic [CLASS_BITS-1:0] class_reg;

    function automatic place_t place_of(input logic signed [SW-1:0] n,
                                        input logic signed [SW-1:0] d);
        logic signed [SW:0] nn;
        logic signed [SW:0] dd;
        place_t             r;
        nn = d[SW-1] ? -((SW+1)'(n)) : (SW+1)'(n);
        dd = d[SW-1] ? -((SW+1)'(d)) : (SW+1)'(d);
        priority if (nn == '0)
            r = PLACE_ZERO;
        else if (nn == dd)
            r = PLACE_ONE;
        else if (nn > 0 && nn < dd)
            r = PLACE_MID;
        else
            r = PLACE_OUT;
        return r;
    endfunction

    assign rdy6     = !v6_reg || out_ready;
    assign rdy5     = !v5_reg || rdy6;
    assign rdy4     = !v4_reg || rdy5;
    assign in_ready = rdy4;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (rdy4)
                v4_reg <= in_valid;
            if (rdy5)
                v5_reg <= v4_reg;
            if (rdy6)
                v6_reg <= v5_reg;
        end
    end

    // Stage 4: the three cross products.
    assign d_next  = SW'(p_rx_sy) - SW'(p_ry_sx);
    assign sn_next = SW'(p_qx_ry) - SW'(p_qy_rx);
    assign rn_next = SW'(p_qx_sy) - SW'(p_qy_sx);

    always_ff @(posedge clk)
    begin
        if (rdy4 && in_valid)
        begin
            d_reg      <= d_next;
            sn_reg     <= sn_next;
            rn_reg     <= rn_next;
            flags4_reg <= in_flags;
        end
    end

    // Stage 5: exact placement of rn/d and sn/d.
    assign pr_next = place_of(rn_reg, d_reg);
    assign ps_next = place_of(sn_reg, d_reg);

    always_ff @(posedge clk)
    begin
        if (rdy5 && v4_reg)
        begin
            pr_reg      <= pr_next;
            ps_reg      <= ps_next;
            d_zero_reg  <= (d_reg == '0);
            sn_zero_reg <= (sn_reg == '0);
            rn_zero_reg <= (rn_reg == '0);
            flags5_reg  <= flags4_reg;
        end
    end

    // Stage 6: class of two segments with a nonzero denominator.
    always_comb
    begin
        priority if ((pr_reg == PLACE_ZERO || pr_reg == PLACE_ONE) &&
                     (ps_reg == PLACE_ZERO || ps_reg == PLACE_ONE))
            cross_cls = CLS_SHARED;
        else if (ps_reg == PLACE_ONE && pr_reg == PLACE_MID)
            cross_cls = CLS_B_END;
        else if (ps_reg == PLACE_ZERO && pr_reg == PLACE_MID)
            cross_cls = CLS_B_START;
        else if (pr_reg == PLACE_ONE && ps_reg == PLACE_MID)
            cross_cls = CLS_A_END;
        else if (pr_reg == PLACE_ZERO && ps_reg == PLACE_MID)
            cross_cls = CLS_A_START;
        else if (pr_reg == PLACE_MID && ps_reg == PLACE_MID)
            cross_cls = CLS_PROPER;
        else
            cross_cls = CLS_NONE;
    end

    // A point lies on a slanted segment only if its cross product vanishes:
    // that is rn for a point A and sn for a point B.
    always_comb
    begin
        unique case (flags5_reg.kind)
            KIND_FIXED:
                class_next = flags5_reg.fixed_class;
            KIND_PT_A:
                class_next = rn_zero_reg ? flags5_reg.pt_class : CLS_NONE;
            KIND_PT_B:
                class_next = sn_zero_reg ? flags5_reg.pt_class : CLS_NONE;
            default:
            begin
                priority if (!d_zero_reg)
                    class_next = cross_cls;
                else if (sn_zero_reg)
                    class_next = flags5_reg.col_class;
                else
                    class_next = CLS_NONE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rdy6 && v5_reg)
            class_reg <= class_next;
    end

    assign out_valid      = v6_reg;
    assign crossing_class = class_reg;

    a_out_from_stage5: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(v6_reg) |-> $past(v5_reg))
        else $error("output beat appeared without a placed item behind it");

    a_point_zero_denominator: assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && (flags4_reg.kind == KIND_PT_A || flags4_reg.kind == KIND_PT_B))
        |-> (d_reg == '0))
        else $error("point segment produced a nonzero denominator");

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (v4_reg && v5_reg && v6_reg))
        else $error("decide stages refused a beat with a free stage");

endmodule

`default_nettype wire

/* hw/rtl/segment_pair_crossing_classifier.sv */
// ============================================================================
// segment_pair_crossing_classifier: exact crossing class of two segments
// Classifies a pair of integer line segments as no crossing, shared
// endpoint, proper crossing, crossing at one endpoint or collinear overlap,
// using integer cross products compared exactly as rationals.
//
//   channel  | dir | beat contents
//   ---------+-----+--------------------------------------------------------
//   s_t*     | in  | one segment pair: 8 coordinates of 16 bits each
//   m_t*     | out | crossing class, 3 bits in an 8-bit tdata
//
// One pair enters per cycle unless m_tready stalls the pipeline; each beat
// passes through capture, differences, products, cross products, placement, class.
// The six stages carry their own valid bits, so an empty stage fills even
// while the output holds a beat, and a stall on m_tready backs up stage by
// stage to s_tready without losing or repeating a beat.
// Reset clears only the stage valid bits.
// ============================================================================
`default_nettype none

module segment_pair_crossing_classifier
    import spcc_pkg::*;
#(
    parameter int unsigned COORD_BITS = 16
)(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // From bit 0: a_start_x, a_start_y, a_end_x, a_end_y,
    // b_start_x, b_start_y, b_end_x, b_end_y (16 bits each).
    input  wire logic [IN_BITS-1:0]  s_tdata,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // From bit 0: crossing_class (3 bits), zeros above.
    output logic [OUT_BITS-1:0]      m_tdata
);

    localparam int unsigned DW = COORD_BITS + 1;
    localparam int unsigned PW = 2 * DW;

    logic                  prep_valid, prep_ready;
    logic signed [DW-1:0]  rx, ry, sx, sy, qx, qy;
    flags_t                prep_flags;
    logic                  mult_valid, mult_ready;
    logic signed [PW-1:0]  p_rx_sy, p_ry_sx, p_qx_ry, p_qy_rx, p_qx_sy, p_qy_sx;
    flags_t                mult_flags;
    logic [CLASS_BITS-1:0] crossing_class;

    spcc_prep #(
        .COORD_BITS (COORD_BITS)
    ) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .out_valid (prep_valid),
        .out_ready (prep_ready),
        .rx        (rx),
        .ry        (ry),
        .sx        (sx),
        .sy        (sy),
        .qx        (qx),
        .qy        (qy),
        .flags     (prep_flags)
    );

    spcc_mult #(
        .COORD_BITS (COORD_BITS)
    ) u_mult (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prep_valid),
        .in_ready  (prep_ready),
        .rx        (rx),
        .ry        (ry),
        .sx        (sx),
        .sy        (sy),
        .qx        (qx),
        .qy        (qy),
        .in_flags  (prep_flags),
        .out_valid (mult_valid),
        .out_ready (mult_ready),
        .p_rx_sy   (p_rx_sy),
        .p_ry_sx   (p_ry_sx),
        .p_qx_ry   (p_qx_ry),
        .p_qy_rx   (p_qy_rx),
        .p_qx_sy   (p_qx_sy),
        .p_qy_sx   (p_qy_sx),
        .out_flags (mult_flags)
    );

    spcc_decide #(
        .COORD_BITS (COORD_BITS)
    ) u_decide (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (mult_valid),
        .in_ready       (mult_ready),
        .p_rx_sy        (p_rx_sy),
        .p_ry_sx        (p_ry_sx),
        .p_qx_ry        (p_qx_ry),
        .p_qy_rx        (p_qy_rx),
        .p_qx_sy        (p_qx_sy),
        .p_qy_sx        (p_qy_sx),
        .in_flags       (mult_flags),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .crossing_class (crossing_class)
    );

    assign m_tdata = {{(OUT_BITS-CLASS_BITS){1'b0}}, crossing_class};

    // The input only stalls when every stage, the output included, is full.
    a_input_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled while the output register was empty");

    a_stall_not_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (!s_tready && !m_tready) |=> m_tvalid)
        else $error("stalled output beat vanished");

    a_ready_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input refused a beat with an empty output stage");

endmodule

`default_nettype wire
